>>> rtl/core/tsdf_pkg.sv
// ----------------------------------------------------------------------------
// tsdf_pkg
// Shared types, constants and tables of the TSDF voxel fusion core.
// ----------------------------------------------------------------------------
package tsdf_pkg;

    localparam int GRID_SIDE_DEF = 64;
    localparam int QUEUE_DEPTH   = 4;
    localparam int APB_ADDR_W    = 5;
    localparam int APB_DATA_W    = 32;

    localparam logic [30:0] TRUNC_DIST_RST     = 31'd2621;
    localparam logic [30:0] TRUNC_DIST_INV_RST = 31'd1638400;
    localparam logic [31:0] DEPTH_SCALE_RST    = 32'd858993;
    localparam logic [7:0]  MAX_WEIGHT_RST     = 8'd64;

    localparam logic [15:0]       RESET_ENTRY       = 16'hFF00;
    localparam logic signed [7:0] OUT_OF_RANGE_CODE = -8'sd128;

    // reciprocal table for the weighted average: floor(2^SHIFT / d) + 1
    localparam int RECIP_SHIFT   = 24;
    localparam int RECIP_W       = RECIP_SHIFT + 1;
    localparam int RECIP_ENTRIES = 257;

    typedef logic [RECIP_W-1:0] recip_table_t [RECIP_ENTRIES];

    typedef enum logic [2:0] {
        ST_UPDATED  = 3'd0,
        ST_BEHIND   = 3'd1,
        ST_NO_DEPTH = 3'd2,
        ST_FAR      = 3'd3,
        ST_READ     = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        REG_TRUNC_DIST     = 3'd0,
        REG_TRUNC_DIST_INV = 3'd1,
        REG_DEPTH_SCALE    = 3'd2,
        REG_MAX_WEIGHT     = 3'd3,
        REG_Z_FIRST_ORDER  = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic [30:0] trunc_dist;
        logic [30:0] trunc_dist_inv;
        logic [31:0] depth_scale;
        logic [7:0]  max_weight;
        logic        z_first_order;
    } cfg_t;

    typedef struct packed {
        logic              oor;
        status_t           status;
        logic signed [7:0] q;
    } item_t;

    // long division at elaboration, no divider in hardware
    function automatic recip_table_t build_recip_table();
        recip_table_t t;
        logic [31:0]  rem;
        logic [31:0]  quo;
        t[0] = '0;
        for (int d = 1; d < RECIP_ENTRIES; d++)
        begin
            rem = '0;
            quo = '0;
            for (int b = RECIP_SHIFT; b >= 0; b--)
            begin
                rem = {rem[30:0], (b == RECIP_SHIFT)};
                if (rem >= 32'(d))
                begin
                    rem    = rem - 32'(d);
                    quo[b] = 1'b1;
                end
            end
            t[d] = RECIP_W'(quo + 32'd1);
        end
        return t;
    endfunction

    localparam recip_table_t RECIP_TABLE = build_recip_table();

endpackage

>>> rtl/core/tsdf_stream_if.sv
// ----------------------------------------------------------------------------
// tsdf_stream_if
// Valid/ready channels for observations in and voxel results out.
// ----------------------------------------------------------------------------
interface tsdf_in_if;
    logic              valid;
    logic              ready;
    logic              op;
    logic signed [7:0] voxel_x;
    logic signed [7:0] voxel_y;
    logic signed [7:0] voxel_z;
    logic signed [31:0] cam_depth;
    logic [23:0]       meas_depth;
    logic              meas_valid;
    logic [17:0]       ray_norm;

    modport source (output valid, op, voxel_x, voxel_y, voxel_z, cam_depth,
                    meas_depth, meas_valid, ray_norm, input ready);
    modport sink   (input valid, op, voxel_x, voxel_y, voxel_z, cam_depth,
                    meas_depth, meas_valid, ray_norm, output ready);
endinterface

interface tsdf_out_if;
    logic              valid;
    logic              ready;
    logic [2:0]        status;
    logic signed [7:0] dist_code;
    logic [7:0]        weight;

    modport source (output valid, status, dist_code, weight, input ready);
    modport sink   (input valid, status, dist_code, weight, output ready);
endinterface

>>> rtl/core/tsdf_ram.sv
// ----------------------------------------------------------------------------
// tsdf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tsdf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/tsdf_front.sv
// ----------------------------------------------------------------------------
// tsdf_front
// Accepts observations, checks range, computes the address, the skip status
// and the quantized distance code over a five-stage pipeline.
// ----------------------------------------------------------------------------
module tsdf_front import tsdf_pkg::*; #(
    parameter int GRID_SIDE = GRID_SIDE_DEF,
    localparam int AW       = $clog2(GRID_SIDE * GRID_SIDE * GRID_SIDE)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          hold,
    input  cfg_t          cfg,
    tsdf_in_if.sink       in_ch,
    input  logic          q_full,
    output logic          push,
    output logic [AW-1:0] push_addr,
    output item_t         push_item
);

    localparam int PLANE = GRID_SIDE * GRID_SIDE;

    function automatic logic in_grid(input logic signed [7:0] c);
        return !c[7] && (int'(c) < GRID_SIDE);
    endfunction

    logic adv;
    logic accept;

    // stage 0
    logic                s0_valid_reg;
    logic [AW-1:0]       s0_addr_reg;
    logic                s0_oor_reg;
    status_t             s0_status_reg;
    logic [55:0]         s0_p40_reg;
    logic signed [31:0]  s0_cam_reg;
    logic [17:0]         s0_norm_reg;
    // stage 1
    logic                s1_valid_reg;
    logic [AW-1:0]       s1_addr_reg;
    logic                s1_oor_reg;
    status_t             s1_status_reg;
    logic signed [33:0]  s1_d16_reg;
    logic [17:0]         s1_norm_reg;
    // stage 2
    logic                s2_valid_reg;
    logic [AW-1:0]       s2_addr_reg;
    logic                s2_oor_reg;
    status_t             s2_status_reg;
    logic signed [52:0]  s2_s32_reg;
    // stage 3
    logic                s3_valid_reg;
    logic [AW-1:0]       s3_addr_reg;
    logic                s3_oor_reg;
    status_t             s3_status_reg;
    logic signed [68:0]  s3_prod_reg;
    // stage 4
    logic                s4_valid_reg;
    logic [AW-1:0]       s4_addr_reg;
    logic                s4_oor_reg;
    status_t             s4_status_reg;
    logic signed [7:0]   s4_q_reg;

    logic                in_range;
    logic [7:0]          hi_idx;
    logic [7:0]          lo_idx;
    logic [AW-1:0]       addr_next;
    status_t             status_next;
    logic [55:0]         p40_next;
    logic signed [57:0]  c40;
    logic signed [57:0]  diff;
    logic signed [52:0]  s32_next;
    logic signed [52:0]  far_lim;
    logic                far;
    status_t             s3_status_next;
    logic signed [68:0]  prod_next;
    logic [68:0]         mag;
    logic                big;
    logic [6:0]          seven;
    logic signed [7:0]   q_next;

    assign adv          = !s4_valid_reg || !q_full;
    assign in_ch.ready  = adv && !hold;
    assign accept       = in_ch.valid && in_ch.ready;

    always_comb
    begin
        in_range = in_grid(in_ch.voxel_x) && in_grid(in_ch.voxel_y)
                   && in_grid(in_ch.voxel_z);
        hi_idx   = cfg.z_first_order ? in_ch.voxel_x : in_ch.voxel_z;
        lo_idx   = cfg.z_first_order ? in_ch.voxel_z : in_ch.voxel_x;
        addr_next = AW'(hi_idx) * AW'(PLANE) + AW'(in_ch.voxel_y) * AW'(GRID_SIDE)
                    + AW'(lo_idx);
        if (in_ch.op)
            status_next = ST_READ;
        else if (in_ch.cam_depth <= 32'sd0)
            status_next = ST_BEHIND;
        else if (!in_ch.meas_valid || (in_ch.meas_depth == 24'd0))
            status_next = ST_NO_DEPTH;
        else
            status_next = ST_UPDATED;
        p40_next = 56'(in_ch.meas_depth) * 56'(cfg.depth_scale);
    end

    always_comb
    begin
        c40  = {{2{s0_cam_reg[31]}}, s0_cam_reg, 24'd0};
        diff = $signed({2'b00, s0_p40_reg}) - c40;
    end

    assign s32_next = s1_d16_reg * $signed({1'b0, s1_norm_reg});

    always_comb
    begin
        far_lim   = -$signed({6'd0, cfg.trunc_dist, 16'd0});
        far       = s2_s32_reg < far_lim;
        prod_next = $signed(s2_s32_reg[52:16]) * $signed({1'b0, cfg.trunc_dist_inv});
        s3_status_next = s2_status_reg;
        if ((s2_status_reg == ST_UPDATED) && far)
            s3_status_next = ST_FAR;
    end

    // quantize: code = -trunc(n / 2^25), clamped; zero maps to -1 or 1
    always_comb
    begin
        mag   = s3_prod_reg[68] ? 69'(-s3_prod_reg) : 69'(s3_prod_reg);
        big   = |mag[68:32];
        seven = mag[31:25];
        if (s3_prod_reg[68])
        begin
            if (big)
                q_next = 8'sd127;
            else if (seven == 7'd0)
                q_next = 8'sd1;
            else
                q_next = $signed({1'b0, seven});
        end
        else
        begin
            if (big)
                q_next = -8'sd128;
            else if (seven == 7'd0)
                q_next = -8'sd1;
            else
                q_next = -$signed({1'b0, seven});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s0_valid_reg <= accept;
            s1_valid_reg <= s0_valid_reg;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s0_addr_reg   <= addr_next;
            s0_oor_reg    <= !in_range;
            s0_status_reg <= status_next;
            s0_p40_reg    <= p40_next;
            s0_cam_reg    <= in_ch.cam_depth;
            s0_norm_reg   <= in_ch.ray_norm;

            s1_addr_reg   <= s0_addr_reg;
            s1_oor_reg    <= s0_oor_reg;
            s1_status_reg <= s0_status_reg;
            s1_d16_reg    <= diff[57:24];
            s1_norm_reg   <= s0_norm_reg;

            s2_addr_reg   <= s1_addr_reg;
            s2_oor_reg    <= s1_oor_reg;
            s2_status_reg <= s1_status_reg;
            s2_s32_reg    <= s32_next;

            s3_addr_reg   <= s2_addr_reg;
            s3_oor_reg    <= s2_oor_reg;
            s3_status_reg <= s3_status_next;
            s3_prod_reg   <= prod_next;

            s4_addr_reg   <= s3_addr_reg;
            s4_oor_reg    <= s3_oor_reg;
            s4_status_reg <= s3_status_reg;
            s4_q_reg      <= q_next;
        end
    end

    assign push             = s4_valid_reg && !q_full;
    assign push_addr        = s4_addr_reg;
    assign push_item.oor    = s4_oor_reg;
    assign push_item.status = s4_status_reg;
    assign push_item.q      = s4_q_reg;

endmodule

>>> rtl/core/tsdf_queue.sv
// ----------------------------------------------------------------------------
// tsdf_queue
// Short FIFO between the classifying front and the voxel update back end.
// ----------------------------------------------------------------------------
module tsdf_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    localparam int PW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic             full,
    output logic             head_valid,
    output logic [WIDTH-1:0] head_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [PW:0]      count_reg;
    logic [PW-1:0]    wr_ptr_next;
    logic [PW-1:0]    rd_ptr_next;
    logic [PW:0]      count_next;

    assign full       = count_reg == (PW+1)'(DEPTH);
    assign head_valid = count_reg != '0;
    assign head_data  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> rtl/core/tsdf_back.sv
// ----------------------------------------------------------------------------
// tsdf_back
// Voxel store with clearing pass, read-modify-write of the weighted average
// and the result register.
// ----------------------------------------------------------------------------
module tsdf_back import tsdf_pkg::*; #(
    parameter int GRID_SIDE = GRID_SIDE_DEF,
    localparam int CELLS    = GRID_SIDE * GRID_SIDE * GRID_SIDE,
    localparam int AW       = $clog2(CELLS)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  cfg_t          cfg,
    input  logic          head_valid,
    input  logic [AW-1:0] head_addr,
    input  item_t         head_item,
    output logic          pop,
    output logic          clearing,
    tsdf_out_if.source    out_ch
);

    logic          clear_active_reg;
    logic [AW-1:0] clear_cnt_reg;

    logic          back_en;
    logic          hazard;
    logic          issue;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [15:0]   ram_wdata;
    logic          ram_re;
    logic [15:0]   ram_rdata;

    logic          b1_valid_reg;
    logic [AW-1:0] b1_addr_reg;
    item_t         b1_item_reg;
    logic          b1_wr;

    logic                b2_valid_reg;
    logic [AW-1:0]       b2_addr_reg;
    item_t               b2_item_reg;
    logic signed [7:0]   b2_code_reg;
    logic [7:0]          b2_w_reg;
    logic [15:0]         b2_mag_reg;
    logic                b2_neg_reg;
    logic                b2_pos_reg;
    logic [RECIP_W-1:0]  b2_recip_reg;
    logic [7:0]          b2_nw_reg;
    logic                b2_wr;

    logic                out_valid_reg;
    status_t             out_status_reg;
    logic signed [7:0]   out_code_reg;
    logic [7:0]          out_weight_reg;

    logic signed [7:0]   b1_code;
    logic [7:0]          b1_w;
    logic signed [16:0]  b1_sum;
    logic [8:0]          b1_w1;
    logic [7:0]          b1_nw;

    logic [RECIP_W+15:0] b2_prod;
    logic [16:0]         b2_quot;
    logic signed [7:0]   b2_avg;
    status_t             res_status;
    logic signed [7:0]   res_code;
    logic [7:0]          res_weight;

    assign clearing = clear_active_reg;
    assign back_en  = !out_valid_reg || out_ch.ready;

    assign b1_wr = b1_valid_reg && !b1_item_reg.oor && (b1_item_reg.status == ST_UPDATED);
    assign b2_wr = b2_valid_reg && !b2_item_reg.oor && (b2_item_reg.status == ST_UPDATED);

    // a voxel still being updated in flight must not be read again yet
    assign hazard = !head_item.oor
                    && ((b1_wr && (b1_addr_reg == head_addr))
                        || (b2_wr && (b2_addr_reg == head_addr)));
    assign issue  = head_valid && !clear_active_reg && back_en && !hazard;
    assign pop    = issue;

    assign ram_re    = issue && !head_item.oor;
    assign ram_we    = clear_active_reg || (back_en && b2_wr);
    assign ram_waddr = clear_active_reg ? clear_cnt_reg : b2_addr_reg;
    assign ram_wdata = clear_active_reg ? RESET_ENTRY : {b2_avg, b2_nw_reg};

    tsdf_ram #(
        .WIDTH (16),
        .DEPTH (CELLS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (head_addr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_active_reg <= 1'b1;
            clear_cnt_reg    <= '0;
        end
        else if (clear_active_reg)
        begin
            clear_cnt_reg <= clear_cnt_reg + 1'b1;
            if (clear_cnt_reg == AW'(CELLS - 1))
                clear_active_reg <= 1'b0;
        end
    end

    // stage 1: stored voxel arrives; sum = code*w + q
    always_comb
    begin
        b1_code = $signed(ram_rdata[15:8]);
        b1_w    = ram_rdata[7:0];
        b1_sum  = b1_code * $signed({1'b0, b1_w}) + 17'(b1_item_reg.q);
        b1_w1   = {1'b0, b1_w} + 9'd1;
        b1_nw   = (b1_w1 > {1'b0, cfg.max_weight}) ? cfg.max_weight : b1_w1[7:0];
    end

    // stage 2: |sum| / (w+1) by reciprocal, truncated toward zero
    always_comb
    begin
        b2_prod = (RECIP_W+16)'(b2_mag_reg) * (RECIP_W+16)'(b2_recip_reg);
        b2_quot = b2_prod[RECIP_SHIFT+16:RECIP_SHIFT];
        if (b2_quot == 17'd0)
            b2_avg = b2_pos_reg ? 8'sd1 : -8'sd1;
        else if (b2_neg_reg)
            b2_avg = (b2_quot >= 17'd128) ? -8'sd128 : -$signed(b2_quot[7:0]);
        else
            b2_avg = (b2_quot > 17'd127) ? 8'sd127 : $signed(b2_quot[7:0]);

        if (b2_item_reg.oor)
        begin
            res_status = ST_READ;
            res_code   = OUT_OF_RANGE_CODE;
            res_weight = 8'd0;
        end
        else if (b2_item_reg.status == ST_UPDATED)
        begin
            res_status = ST_UPDATED;
            res_code   = b2_avg;
            res_weight = b2_nw_reg;
        end
        else
        begin
            res_status = b2_item_reg.status;
            res_code   = b2_code_reg;
            res_weight = b2_w_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg  <= 1'b0;
            b2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (back_en)
        begin
            b1_valid_reg  <= issue;
            b2_valid_reg  <= b1_valid_reg;
            out_valid_reg <= b2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (back_en)
        begin
            b1_addr_reg    <= head_addr;
            b1_item_reg    <= head_item;

            b2_addr_reg    <= b1_addr_reg;
            b2_item_reg    <= b1_item_reg;
            b2_code_reg    <= b1_code;
            b2_w_reg       <= b1_w;
            b2_mag_reg     <= b1_sum[16] ? 16'(-b1_sum) : b1_sum[15:0];
            b2_neg_reg     <= b1_sum[16];
            b2_pos_reg     <= !b1_sum[16] && (b1_sum != 17'sd0);
            b2_recip_reg   <= RECIP_TABLE[b1_w1];
            b2_nw_reg      <= b1_nw;

            out_status_reg <= res_status;
            out_code_reg   <= res_code;
            out_weight_reg <= res_weight;
        end
    end

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.status    = out_status_reg;
    assign out_ch.dist_code = out_code_reg;
    assign out_ch.weight    = out_weight_reg;

    a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && ram_re) |-> (ram_waddr != head_addr))
        else $error("voxel read and write collide on one address");

    a_no_dup_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (b1_wr && b2_wr) |-> (b1_addr_reg != b2_addr_reg))
        else $error("two updates of one voxel in flight");

    a_updated_code_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_status_reg == ST_UPDATED)) |-> (out_code_reg != 8'sd0))
        else $error("updated voxel carries distance code zero");

endmodule

>>> rtl/core/tsdf_voxel_fusion_core.sv
// ----------------------------------------------------------------------------
// tsdf_voxel_fusion_core
// TSDF voxel fusion: integrate observations into and read from a voxel cube.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle while the output is taken; an item hitting a
// voxel still in the store read-modify-write of one of the two items ahead waits.
// Reset: control cleared, registers to defaults, then a clearing pass over all
// GRID_SIDE^3 voxels (262144 at 64) with ready low; APB writes still taken.
// ----------------------------------------------------------------------------
module tsdf_voxel_fusion_core import tsdf_pkg::*; #(
    parameter int GRID_SIDE = GRID_SIDE_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    tsdf_in_if.sink               in_ch,
    tsdf_out_if.source            out_ch
);

    localparam int AW = $clog2(GRID_SIDE * GRID_SIDE * GRID_SIDE);
    localparam int QW = AW + $bits(item_t);

    cfg_t          cfg_reg;
    reg_idx_t      reg_idx;
    logic          cfg_wr;

    logic          clearing;
    logic          q_full;
    logic          push;
    logic [AW-1:0] push_addr;
    item_t         push_item;
    logic          pop;
    logic          head_valid;
    logic [QW-1:0] head_data;

    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[4:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.trunc_dist     <= TRUNC_DIST_RST;
            cfg_reg.trunc_dist_inv <= TRUNC_DIST_INV_RST;
            cfg_reg.depth_scale    <= DEPTH_SCALE_RST;
            cfg_reg.max_weight     <= MAX_WEIGHT_RST;
            cfg_reg.z_first_order  <= 1'b0;
        end
        else if (cfg_wr)
        begin
            case (reg_idx)
                REG_TRUNC_DIST:     cfg_reg.trunc_dist     <= pwdata[30:0];
                REG_TRUNC_DIST_INV: cfg_reg.trunc_dist_inv <= pwdata[30:0];
                REG_DEPTH_SCALE:    cfg_reg.depth_scale    <= pwdata;
                REG_MAX_WEIGHT:     cfg_reg.max_weight     <= pwdata[7:0];
                REG_Z_FIRST_ORDER:  cfg_reg.z_first_order  <= pwdata[0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_TRUNC_DIST:     prdata = {1'b0, cfg_reg.trunc_dist};
            REG_TRUNC_DIST_INV: prdata = {1'b0, cfg_reg.trunc_dist_inv};
            REG_DEPTH_SCALE:    prdata = cfg_reg.depth_scale;
            REG_MAX_WEIGHT:     prdata = {24'd0, cfg_reg.max_weight};
            REG_Z_FIRST_ORDER:  prdata = {31'd0, cfg_reg.z_first_order};
            default:            prdata = '0;
        endcase
    end

    tsdf_front #(
        .GRID_SIDE (GRID_SIDE)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .hold      (clearing),
        .cfg       (cfg_reg),
        .in_ch     (in_ch),
        .q_full    (q_full),
        .push      (push),
        .push_addr (push_addr),
        .push_item (push_item)
    );

    tsdf_queue #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  ({push_addr, push_item}),
        .pop        (pop),
        .full       (q_full),
        .head_valid (head_valid),
        .head_data  (head_data)
    );

    tsdf_back #(
        .GRID_SIDE (GRID_SIDE)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .head_valid (head_valid),
        .head_addr  (head_data[QW-1:$bits(item_t)]),
        .head_item  (item_t'(head_data[$bits(item_t)-1:0])),
        .pop        (pop),
        .clearing   (clearing),
        .out_ch     (out_ch)
    );

endmodule
